@@ hdl/lprc_pkg.sv @@
// Shared constants, command codes and types of the longest prefix route counter.
package lprc_pkg;

   // Table and counter sizes.
   localparam int ROUTES = 16;
   localparam int LINKS  = 16;

   // Counter bank index width (discard counter plus one per link).
   localparam int CIDX_W = $clog2(LINKS + 1);

   // Field widths fixed by the item format.
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 4;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int LINK_W   = 5;
   localparam int CNTI_W   = 5;
   localparam int CNT_W    = 32;
   localparam int RCOUNT_W = 5;

   // Packed beat widths, padded to whole bytes.
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 40;

   // Longest legal prefix length.
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      logic [LINK_W-1:0] link;
   } route_entry_type;

   // Search beat handed from cell to cell.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              found;
      logic [LEN_W-1:0]  best_len;
      logic [LINK_W-1:0] best_link;
   } search_token_type;

endpackage

@@ hdl/lprc_cell.sv @@
// One route table cell: holds a route entry and refines the passing search beat.
module lprc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  lprc_pkg::route_entry_type   wr_entry,
   input  logic                        active,
   input  lprc_pkg::search_token_type  tok_in,
   output lprc_pkg::search_token_type  tok_out
);
   import lprc_pkg::*;

   route_entry_type  entry_ff;
   search_token_type tok_ff;
   search_token_type tok_in_next;
   logic [ADDR_W-1:0] mask;
   logic              hit;
   logic              better;

   // A length of 0 gives an empty mask, 32 a full one.
   assign mask   = ~({ADDR_W{1'b1}} >> entry_ff.length);
   assign hit    = active && (((tok_in.addr ^ entry_ff.prefix) & mask) == '0);
   assign better = !tok_in.found || (entry_ff.length > tok_in.best_len);

   always_comb begin
      tok_in_next = tok_in;
      if (hit && better) begin
         tok_in_next.found     = 1'b1;
         tok_in_next.best_len  = entry_ff.length;
         tok_in_next.best_link = entry_ff.link;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.addr      <= tok_in_next.addr;
      tok_ff.found     <= tok_in_next.found;
      tok_ff.best_len  <= tok_in_next.best_len;
      tok_ff.best_link <= tok_in_next.best_link;
   end

   assign tok_out = tok_ff;

endmodule

@@ hdl/lprc_counters.sv @@
// Saturating per-link packet counters with one bump port and one read port.
module lprc_counters (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        bump_en,
   input  logic [lprc_pkg::CIDX_W-1:0] bump_idx,
   output logic [lprc_pkg::CNT_W-1:0]  bump_value,
   input  logic [lprc_pkg::CIDX_W-1:0] rd_idx,
   output logic [lprc_pkg::CNT_W-1:0]  rd_value
);
   import lprc_pkg::*;

   logic [CNT_W-1:0] count_ff [LINKS+1];
   logic [CNT_W-1:0] cur;

   assign cur        = count_ff[bump_idx];
   // Hold at all ones.
   assign bump_value = (cur == {CNT_W{1'b1}}) ? cur : cur + CNT_W'(1);
   assign rd_value   = count_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LINKS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (bump_en) begin
         count_ff[bump_idx] <= bump_value;
      end
   end

endmodule

@@ hdl/longest_prefix_route_counter.sv @@
// Top level of the longest prefix route counter: cell chain, counters and beat control.
//
// Takes one request beat at a time. A write beat loads one route slot and a read
// beat fetches one link counter; each answers through the pending and response
// registers. A classify beat enters a chain of ROUTES cells, one per route slot,
// and moves one cell per cycle, each cell keeping the longest matching prefix seen
// so far (the earlier slot wins on equal length). Slots at or above route_count
// pass the beat unchanged. When the beat leaves the last cell the chosen counter
// is bumped, and the result passes through the pending and response registers.
// A new request beat is taken as soon as the previous one has moved to the
// response register, even while that response still waits for rsp_tready.
// Unmatched packets, and matched packets whose link is above LINKS, are counted
// on the discard counter 0. Counters saturate at all ones and clear at reset;
// route slots have no reset and must be written before use.
// Write route_count only while the block is idle.
module longest_prefix_route_counter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lprc_pkg::RCOUNT_W-1:0]   csr_wr_data,  // route_count
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] route_index, [35:4] route_prefix, [41:36] prefix_length,
   // [46:42] route_link, [78:47] packet_address, [83:79] counter_index, rest zero
   input  logic [lprc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [lprc_pkg::CMD_W-1:0]      req_tuser,    // [1:0] cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [4:0] link_chosen, [5] matched, [37:6] counter_value, rest zero
   output logic [lprc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import lprc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_HOLD   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [RCOUNT_W-1:0] route_count_ff;

   // Unpack the request beat.
   logic [CMD_W-1:0]  cmd;
   logic [SLOT_W-1:0] route_index;
   logic [ADDR_W-1:0] route_prefix;
   logic [LEN_W-1:0]  prefix_length;
   logic [LINK_W-1:0] route_link;
   logic [ADDR_W-1:0] packet_address;
   logic [CNTI_W-1:0] counter_index;

   assign cmd            = req_tuser;
   assign route_index    = req_tdata[3:0];
   assign route_prefix   = req_tdata[35:4];
   assign prefix_length  = req_tdata[41:36];
   assign route_link     = req_tdata[46:42];
   assign packet_address = req_tdata[78:47];
   assign counter_index  = req_tdata[83:79];

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Route count register, saturated to the table size.
   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff <= '0;
      end else if (csr_wr_en) begin
         if (32'(csr_wr_data) > ROUTES) begin
            route_count_ff <= RCOUNT_W'(ROUTES);
         end else begin
            route_count_ff <= csr_wr_data;
         end
      end
   end

   // Route write entry, length clamped to 32.
   route_entry_type wr_entry;
   always_comb begin
      wr_entry.prefix = route_prefix;
      wr_entry.length = (prefix_length > MAX_LEN) ? MAX_LEN : prefix_length;
      wr_entry.link   = route_link;
   end

   // Cell chain.
   search_token_type tok [ROUTES+1];
   logic [ROUTES-1:0] tok_valid;

   always_comb begin
      tok[0].valid     = req_fire && (cmd == CMD_CLASSIFY);
      tok[0].addr      = packet_address;
      tok[0].found     = 1'b0;
      tok[0].best_len  = '0;
      tok[0].best_link = '0;
   end

   for (genvar g = 0; g < ROUTES; g++) begin : g_cell
      logic cell_wr;
      logic cell_active;
      assign cell_wr     = req_fire && (cmd == CMD_WRITE) && (32'(route_index) == g);
      assign cell_active = (32'(route_count_ff) > g);
      assign tok_valid[g] = tok[g+1].valid;

      lprc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (cell_wr),
         .wr_entry (wr_entry),
         .active   (cell_active),
         .tok_in   (tok[g]),
         .tok_out  (tok[g+1])
      );
   end

   // Counter bank.
   search_token_type tail;
   logic              bump_en;
   logic [CIDX_W-1:0] bump_idx;
   logic [CNT_W-1:0]  bump_value;
   logic [CIDX_W-1:0] rd_idx;
   logic [CNT_W-1:0]  rd_value;
   logic              rd_in_range;

   assign tail     = tok[ROUTES];
   assign bump_en  = (state_ff == ST_SEARCH) && tail.valid;
   // Send no-match and out-of-range links to the discard counter.
   assign bump_idx = (tail.found && (32'(tail.best_link) <= LINKS)) ?
                     CIDX_W'(tail.best_link) : '0;
   assign rd_in_range = (32'(counter_index) <= LINKS);
   assign rd_idx      = rd_in_range ? CIDX_W'(counter_index) : '0;

   lprc_counters u_counters (
      .clock      (clock),
      .reset      (reset),
      .bump_en    (bump_en),
      .bump_idx   (bump_idx),
      .bump_value (bump_value),
      .rd_idx     (rd_idx),
      .rd_value   (rd_value)
   );

   // Pending result, waiting for the response register.
   logic [LINK_W-1:0] pend_link_ff, pend_link_in;
   logic              pend_hit_ff, pend_hit_in;
   logic [CNT_W-1:0]  pend_value_ff, pend_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      pend_link_in  = pend_link_ff;
      pend_hit_in   = pend_hit_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pend_link_in  = '0;
               pend_hit_in   = 1'b0;
               pend_value_in = '0;
               if (cmd == CMD_CLASSIFY) begin
                  state_in = ST_SEARCH;
               end else begin
                  // Write, read and unknown commands skip the search and go straight to hold.
                  state_in = ST_HOLD;
                  if (cmd == CMD_READ && rd_in_range) begin
                     pend_value_in = rd_value;
                  end
               end
            end
         end
         ST_SEARCH: begin
            if (tail.valid) begin
               pend_link_in  = tail.found ? tail.best_link : '0;
               pend_hit_in   = tail.found;
               pend_value_in = bump_value;
               state_in      = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, pend_value_ff, pend_hit_ff, pend_link_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_link_ff  <= pend_link_in;
      pend_hit_ff   <= pend_hit_in;
      pend_value_ff <= pend_value_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // At most one classify beat travels the chain.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one search beat in the cell chain");

   // A beat leaves the chain only while the search is pending.
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (state_ff == ST_SEARCH))
      else $error("search beat left the chain outside a search");

   // A classify beat enters the first cell on the next cycle.
   a_classify_enters: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (cmd == CMD_CLASSIFY)) |=> (tok[1].valid && state_ff == ST_SEARCH))
      else $error("classify beat did not enter the cell chain");

   // An unmatched response carries link 0.
   a_nomatch_link: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[5]) |-> (rsp_data_ff[4:0] == '0))
      else $error("unmatched response shows a nonzero link");
`endif

endmodule
